@@ src/dppa_pkg.sv @@
// Package for the depth patch proximity alarm: widths, limits, register
// indexes, microcode field codes, the control word type and the control ROM.
// No dependencies; every other file of the block imports it.
package dppa_pkg;

   // Frame and patch limits.
   localparam int MAX_WIDTH   = 640;
   localparam int MAX_HEIGHT  = 480;
   localparam int MAX_PATCH   = 128;
   localparam int MAX_STRIDE  = 128;
   localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);

   // Field and register widths.
   localparam int DEPTH_W    = 16;
   localparam int ALERT_W    = 2;
   localparam int WIDTH_W    = 10;
   localparam int HEIGHT_W   = 9;
   localparam int PATCH_W    = 8;
   localparam int STRIDE_W   = 8;
   localparam int MINPTS_W   = 15;
   localparam int THR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Datapath widths: grid coordinate sums, one row sum, one summed-area entry, a
   // patch pixel count and a threshold times count product.
   localparam int XS_W    = WIDTH_W + 1;
   localparam int YS_W    = HEIGHT_W + 1;
   localparam int ROW_W   = 26;
   localparam int SUM_W   = 35;
   localparam int COUNT_W = 15;
   localparam int PROD_W  = THR_W + COUNT_W;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATCH_SIZE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATCH_STRIDE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_POINTS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_THRESHOLD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WARN_THRESHOLD = 3'd6;

   // Register values after reset.
   localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH    = 10'd640;
   localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT   = 9'd480;
   localparam logic [PATCH_W-1:0]  RST_PATCH_SIZE     = 8'd100;
   localparam logic [STRIDE_W-1:0] RST_PATCH_STRIDE   = 8'd30;
   localparam logic [MINPTS_W-1:0] RST_MIN_POINTS     = 15'd900;
   localparam logic [THR_W-1:0]    RST_STOP_THRESHOLD = 16'd400;
   localparam logic [THR_W-1:0]    RST_WARN_THRESHOLD = 16'd800;

   // Alert codes.
   localparam logic [ALERT_W-1:0] ALERT_CLEAR = 2'd0;
   localparam logic [ALERT_W-1:0] ALERT_WARN  = 2'd1;
   localparam logic [ALERT_W-1:0] ALERT_STOP  = 2'd2;

   // Sequencer steps, in program order.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LOAD       = 4'd0;
   localparam logic [STEP_W-1:0] STEP_BUILD_RD   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_BUILD_ROW  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_BUILD_WR   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_CLIP       = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_COUNT  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MUL_BASE1  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MUL_BASE0  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_READ_A     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_READ_B     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_READ_C     = 4'd10;
   localparam logic [STEP_W-1:0] STEP_READ_D     = 4'd11;
   localparam logic [STEP_W-1:0] STEP_SUM_D      = 4'd12;
   localparam logic [STEP_W-1:0] STEP_TEST_STOP  = 4'd13;
   localparam logic [STEP_W-1:0] STEP_TEST_WARN  = 4'd14;
   localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd15;

   // Summed-area table read address sources.
   localparam logic [2:0] ADDR_BUILD = 3'd0;
   localparam logic [2:0] ADDR_A     = 3'd1;
   localparam logic [2:0] ADDR_B     = 3'd2;
   localparam logic [2:0] ADDR_C     = 3'd3;
   localparam logic [2:0] ADDR_D     = 3'd4;

   // ALU operations.
   localparam logic [2:0] ALU_NOP       = 3'd0;
   localparam logic [2:0] ALU_ROW       = 3'd1;
   localparam logic [2:0] ALU_ACC_LOAD  = 3'd2;
   localparam logic [2:0] ALU_ACC_SUB_B = 3'd3;
   localparam logic [2:0] ALU_ACC_SUB_C = 3'd4;
   localparam logic [2:0] ALU_ACC_ADD_D = 3'd5;
   localparam logic [2:0] ALU_TEST_STOP = 3'd6;
   localparam logic [2:0] ALU_TEST_WARN = 3'd7;

   // Multiplier operand selections; each also names its destination.
   localparam logic [2:0] MUL_NOP   = 3'd0;
   localparam logic [2:0] MUL_COUNT = 3'd1;
   localparam logic [2:0] MUL_BASE1 = 3'd2;
   localparam logic [2:0] MUL_BASE0 = 3'd3;
   localparam logic [2:0] MUL_STOP  = 3'd4;
   localparam logic [2:0] MUL_WARN  = 3'd5;

   // Counter and grid operations.
   localparam logic [2:0] SEQ_NOP       = 3'd0;
   localparam logic [2:0] SEQ_INIT      = 3'd1;
   localparam logic [2:0] SEQ_BUILD_ADV = 3'd2;
   localparam logic [2:0] SEQ_CLIP      = 3'd3;
   localparam logic [2:0] SEQ_GRID_ADV  = 3'd4;

   // Jump conditions.
   localparam logic [2:0] COND_NONE       = 3'd0;
   localparam logic [2:0] COND_FRAME_DONE = 3'd1;
   localparam logic [2:0] COND_BUILD_MORE = 3'd2;
   localparam logic [2:0] COND_GRID_MORE  = 3'd3;
   localparam logic [2:0] COND_OUT_FREE   = 3'd4;

   // One control word. A true condition jumps to target; otherwise the
   // step holds when hold is set and advances by one when it is not.
   typedef struct packed {
      logic              take_pixel;
      logic              emit;
      logic              rd_en;
      logic              wr_en;
      logic [2:0]        addr_sel;
      logic [2:0]        alu_op;
      logic [2:0]        mul_sel;
      logic [2:0]        seq_op;
      logic [2:0]        cond;
      logic              hold;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // Control ROM.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '0;
      case (step)
         STEP_LOAD: begin
            uc.take_pixel = 1'b1;
            uc.seq_op     = SEQ_INIT;
            uc.cond       = COND_FRAME_DONE;
            uc.hold       = 1'b1;
            uc.target     = STEP_BUILD_RD;
         end
         STEP_BUILD_RD: begin
            uc.rd_en    = 1'b1;
            uc.addr_sel = ADDR_BUILD;
         end
         STEP_BUILD_ROW: begin
            uc.alu_op = ALU_ROW;
         end
         STEP_BUILD_WR: begin
            uc.wr_en  = 1'b1;
            uc.seq_op = SEQ_BUILD_ADV;
            uc.cond   = COND_BUILD_MORE;
            uc.target = STEP_BUILD_RD;
         end
         STEP_CLIP: begin
            uc.seq_op = SEQ_CLIP;
         end
         STEP_MUL_COUNT: begin
            uc.mul_sel = MUL_COUNT;
         end
         STEP_MUL_BASE1: begin
            uc.mul_sel = MUL_BASE1;
         end
         STEP_MUL_BASE0: begin
            uc.mul_sel = MUL_BASE0;
         end
         STEP_READ_A: begin
            uc.rd_en    = 1'b1;
            uc.addr_sel = ADDR_A;
         end
         STEP_READ_B: begin
            uc.rd_en    = 1'b1;
            uc.addr_sel = ADDR_B;
            uc.alu_op   = ALU_ACC_LOAD;
         end
         STEP_READ_C: begin
            uc.rd_en    = 1'b1;
            uc.addr_sel = ADDR_C;
            uc.alu_op   = ALU_ACC_SUB_B;
         end
         STEP_READ_D: begin
            uc.rd_en    = 1'b1;
            uc.addr_sel = ADDR_D;
            uc.alu_op   = ALU_ACC_SUB_C;
         end
         STEP_SUM_D: begin
            uc.alu_op  = ALU_ACC_ADD_D;
            uc.mul_sel = MUL_STOP;
         end
         STEP_TEST_STOP: begin
            uc.alu_op  = ALU_TEST_STOP;
            uc.mul_sel = MUL_WARN;
         end
         STEP_TEST_WARN: begin
            uc.alu_op = ALU_TEST_WARN;
            uc.seq_op = SEQ_GRID_ADV;
            uc.cond   = COND_GRID_MORE;
            uc.target = STEP_CLIP;
         end
         STEP_EMIT: begin
            uc.emit   = 1'b1;
            uc.cond   = COND_OUT_FREE;
            uc.hold   = 1'b1;
            uc.target = STEP_LOAD;
         end
         default: begin
            uc.target = STEP_LOAD;
            uc.cond   = COND_NONE;
         end
      endcase
      return uc;
   endfunction

endpackage

@@ src/dppa_req_if.sv @@
// Input channel of the depth patch proximity alarm: one depth pixel a transfer.
// Depends on dppa_pkg for the pixel width.
interface dppa_req_if import dppa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_value;

   modport source (output valid, output depth_value, input ready);
   modport sink (input valid, input depth_value, output ready);
endinterface

@@ src/dppa_rsp_if.sv @@
// Result channel of the depth patch proximity alarm: one alert level a frame.
// Depends on dppa_pkg for the alert width.
interface dppa_rsp_if import dppa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ALERT_W-1:0] alert_level;

   modport source (output valid, output alert_level, input ready);
   modport sink (input valid, input alert_level, output ready);
endinterface

@@ src/depth_patch_proximity_alarm_top.sv @@
// Depth patch proximity alarm: frame store, summed-area table builder and
// strided patch walk, run by a microcoded sequencer.
// Depends on dppa_pkg, dppa_req_if and dppa_rsp_if.
//
//   channel   direction  payload                 handshake
//   req_ch    in         depth_value  16 bits     valid / ready
//   rsp_ch    out        alert_level   2 bits     valid / ready
//   csr_*     in         index 3, data 16 bits    write enable, no wait
//
// A frame of W*H pixels loads at one pixel per cycle while req_ch.valid is high.
// The sequencer then builds the summed-area table with a read, a row-sum and a
// write step per pixel (one read port per memory) and walks ceil(W/stride) *
// ceil(H/stride) patches: clip, multiplies, corner reads, sum, stop and warn tests.
// Reset is synchronous with no clearing pass: the table is rebuilt in full for
// every frame. The result register holds an alert while the next frame loads; a
// walk that finishes while that alert is still untaken waits at its emit step.
module depth_patch_proximity_alarm_top import dppa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dppa_req_if.sink              req_ch,
   dppa_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // Configuration registers.
   logic [WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic [PATCH_W-1:0]  patch_size_ff, patch_size_in;
   logic [STRIDE_W-1:0] patch_stride_ff, patch_stride_in;
   logic [MINPTS_W-1:0] min_points_ff, min_points_in;
   logic [THR_W-1:0]    stop_thr_ff, stop_thr_in;
   logic [THR_W-1:0]    warn_thr_ff, warn_thr_in;

   // Geometry in use.
   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [PATCH_W-1:0]  ps_eff;
   logic [STRIDE_W-1:0] st_eff;
   logic [ADDR_W-1:0]   total_px;

   // Sequencer.
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;
   logic              cond_true;

   // Load side.
   logic              accept;
   logic              frame_done;
   logic [ADDR_W-1:0] pix_next;
   logic [ADDR_W-1:0] pixel_counter_ff, pixel_counter_in;

   // Table build counters.
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [WIDTH_W-1:0]  cx_ff, cx_in;
   logic [HEIGHT_W-1:0] cy_ff, cy_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                build_last;

   // Patch grid.
   logic [WIDTH_W-1:0]  x0_ff, x0_in, x1_ff, x1_in;
   logic [HEIGHT_W-1:0] y0_ff, y0_in, y1_ff, y1_in;
   logic [XS_W-1:0]     nx, xe;
   logic [YS_W-1:0]     ny, ye;
   logic                x_more, y_more, grid_more;
   logic                x0_zero, y0_zero;
   logic [WIDTH_W-1:0]  dx, x1m1, x0m1;
   logic [HEIGHT_W-1:0] dy, y0m1;

   // Multiplier and its destinations.
   logic [THR_W-1:0]   mul_a;
   logic [COUNT_W-1:0] mul_b;
   logic [PROD_W-1:0]  product;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  base1_ff, base1_in, base0_ff, base0_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // Memories and patch sum.
   logic [DEPTH_W-1:0] frame_mem [FRAME_DEPTH];
   logic [SUM_W-1:0]   sat_mem [FRAME_DEPTH];
   logic [DEPTH_W-1:0] frame_q_ff;
   logic [SUM_W-1:0]   sat_q_ff;
   logic [ADDR_W-1:0]  sat_rd_addr;
   logic [SUM_W-1:0]   sat_wr_data;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic               qualify, below;

   // Flags and result register.
   logic               stop_ff, stop_in, warn_ff, warn_in;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ALERT_W-1:0] alert_ff, alert_in;

   // Configuration writes.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      patch_size_in   = patch_size_ff;
      patch_stride_in = patch_stride_ff;
      min_points_in   = min_points_ff;
      stop_thr_in     = stop_thr_ff;
      warn_thr_in     = warn_thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:    frame_width_in  = csr_wr_data[WIDTH_W-1:0];
            REG_FRAME_HEIGHT:   frame_height_in = csr_wr_data[HEIGHT_W-1:0];
            REG_PATCH_SIZE:     patch_size_in   = csr_wr_data[PATCH_W-1:0];
            REG_PATCH_STRIDE:   patch_stride_in = csr_wr_data[STRIDE_W-1:0];
            REG_MIN_POINTS:     min_points_in   = csr_wr_data[MINPTS_W-1:0];
            REG_STOP_THRESHOLD: stop_thr_in     = csr_wr_data[THR_W-1:0];
            REG_WARN_THRESHOLD: warn_thr_in     = csr_wr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Geometry saturated to its legal range; zero acts as one.
   always_comb begin
      if (frame_width_ff == '0)
         w_eff = WIDTH_W'(1);
      else if (frame_width_ff > WIDTH_W'(MAX_WIDTH))
         w_eff = WIDTH_W'(MAX_WIDTH);
      else
         w_eff = frame_width_ff;

      if (frame_height_ff == '0)
         h_eff = HEIGHT_W'(1);
      else if (frame_height_ff > HEIGHT_W'(MAX_HEIGHT))
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      else
         h_eff = frame_height_ff;

      if (patch_size_ff == '0)
         ps_eff = PATCH_W'(1);
      else if (patch_size_ff > PATCH_W'(MAX_PATCH))
         ps_eff = PATCH_W'(MAX_PATCH);
      else
         ps_eff = patch_size_ff;

      if (patch_stride_ff == '0)
         st_eff = STRIDE_W'(1);
      else if (patch_stride_ff > STRIDE_W'(MAX_STRIDE))
         st_eff = STRIDE_W'(MAX_STRIDE);
      else
         st_eff = patch_stride_ff;
   end

   assign total_px = ADDR_W'(w_eff) * ADDR_W'(h_eff);

   // Control word of the current step.
   assign uc = ucode_rom(step_ff);

   // Pixel load: the frame completes on the transfer that reaches W*H.
   assign req_ch.ready = uc.take_pixel;
   assign accept       = req_ch.valid && uc.take_pixel;
   assign pix_next     = pixel_counter_ff + ADDR_W'(1);
   assign frame_done   = accept && (pix_next >= total_px);

   always_comb begin
      pixel_counter_in = pixel_counter_ff;
      if (frame_done)
         pixel_counter_in = '0;
      else if (accept)
         pixel_counter_in = pix_next;
   end

   // Grid arithmetic.
   assign nx        = XS_W'(x0_ff) + XS_W'(st_eff);
   assign ny        = YS_W'(y0_ff) + YS_W'(st_eff);
   assign xe        = XS_W'(x0_ff) + XS_W'(ps_eff);
   assign ye        = YS_W'(y0_ff) + YS_W'(ps_eff);
   assign x_more    = nx < XS_W'(w_eff);
   assign y_more    = ny < YS_W'(h_eff);
   assign grid_more = x_more || y_more;
   assign x0_zero   = (x0_ff == '0);
   assign y0_zero   = (y0_ff == '0);
   assign dx        = x1_ff - x0_ff;
   assign dy        = y1_ff - y0_ff;
   assign x1m1      = x1_ff - WIDTH_W'(1);
   assign x0m1      = x0_zero ? '0 : x0_ff - WIDTH_W'(1);
   assign y0m1      = y0_zero ? '0 : y0_ff - HEIGHT_W'(1);

   assign build_last = (cx_ff == w_eff - WIDTH_W'(1)) && (cy_ff == h_eff - HEIGHT_W'(1));

   // Counter and grid updates.
   always_comb begin
      idx_in = idx_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      x0_in  = x0_ff;
      y0_in  = y0_ff;
      x1_in  = x1_ff;
      y1_in  = y1_ff;
      case (uc.seq_op)
         SEQ_INIT: begin
            idx_in = '0;
            cx_in  = '0;
            cy_in  = '0;
            x0_in  = '0;
            y0_in  = '0;
         end
         SEQ_BUILD_ADV: begin
            idx_in = idx_ff + ADDR_W'(1);
            if (cx_ff == w_eff - WIDTH_W'(1)) begin
               cx_in = '0;
               cy_in = cy_ff + HEIGHT_W'(1);
            end else begin
               cx_in = cx_ff + WIDTH_W'(1);
            end
         end
         SEQ_CLIP: begin
            x1_in = (xe < XS_W'(w_eff)) ? xe[WIDTH_W-1:0] : w_eff;
            y1_in = (ye < YS_W'(h_eff)) ? ye[HEIGHT_W-1:0] : h_eff;
         end
         SEQ_GRID_ADV: begin
            if (y_more) begin
               y0_in = ny[HEIGHT_W-1:0];
            end else begin
               y0_in = '0;
               x0_in = nx[WIDTH_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // Shared multiplier: patch count, row bases and threshold products.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      count_in = count_ff;
      base1_in = base1_ff;
      base0_in = base0_ff;
      prod_in  = prod_ff;
      case (uc.mul_sel)
         MUL_COUNT: begin
            mul_a = THR_W'(dx);
            mul_b = COUNT_W'(dy);
         end
         MUL_BASE1: begin
            mul_a = THR_W'(y1_ff - HEIGHT_W'(1));
            mul_b = COUNT_W'(w_eff);
         end
         MUL_BASE0: begin
            mul_a = THR_W'(y0m1);
            mul_b = COUNT_W'(w_eff);
         end
         MUL_STOP: begin
            mul_a = stop_thr_ff;
            mul_b = count_ff;
         end
         MUL_WARN: begin
            mul_a = warn_thr_ff;
            mul_b = count_ff;
         end
         default: ;
      endcase
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
      case (uc.mul_sel)
         MUL_COUNT: count_in = product[COUNT_W-1:0];
         MUL_BASE1: base1_in = product[ADDR_W-1:0];
         MUL_BASE0: base0_in = product[ADDR_W-1:0];
         MUL_STOP,
         MUL_WARN:  prod_in  = product;
         default: ;
      endcase
   end

   // Table read address; corners on a zero row or column are masked later.
   always_comb begin
      case (uc.addr_sel)
         ADDR_BUILD: sat_rd_addr = (cy_ff == '0) ? idx_ff : idx_ff - ADDR_W'(w_eff);
         ADDR_A:     sat_rd_addr = base1_ff + ADDR_W'(x1m1);
         ADDR_B:     sat_rd_addr = base0_ff + ADDR_W'(x1m1);
         ADDR_C:     sat_rd_addr = base1_ff + ADDR_W'(x0m1);
         ADDR_D:     sat_rd_addr = base0_ff + ADDR_W'(x0m1);
         default:    sat_rd_addr = idx_ff;
      endcase
   end

   // New table entry: the entry above plus the running row sum.
   assign sat_wr_data = ((cy_ff == '0) ? '0 : sat_q_ff) + SUM_W'(row_ff);

   // Frame store: written by pixel transfers, read while the table is built.
   always_ff @(posedge clock) begin
      if (accept && (pixel_counter_ff < ADDR_W'(FRAME_DEPTH)))
         frame_mem[pixel_counter_ff] <= req_ch.depth_value;
      if (uc.rd_en)
         frame_q_ff <= frame_mem[idx_ff];
   end

   // Summed-area table, one entry per pixel, row and column zero implied.
   always_ff @(posedge clock) begin
      if (uc.wr_en)
         sat_mem[idx_ff] <= sat_wr_data;
      if (uc.rd_en)
         sat_q_ff <= sat_mem[sat_rd_addr];
   end

   // ALU: row sums, four-corner patch total and the threshold tests.
   assign qualify = (count_ff >= min_points_ff);
   assign below   = (acc_ff <= SUM_W'(prod_ff));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      row_in  = row_ff;
      acc_in  = acc_ff;
      stop_in = stop_ff;
      warn_in = warn_ff;
      case (uc.alu_op)
         ALU_ROW:       row_in = ((cx_ff == '0) ? '0 : row_ff) + ROW_W'(frame_q_ff);
         ALU_ACC_LOAD:  acc_in = sat_q_ff;
         ALU_ACC_SUB_B: if (!y0_zero) acc_in = acc_ff - sat_q_ff;
         ALU_ACC_SUB_C: if (!x0_zero) acc_in = acc_ff - sat_q_ff;
         ALU_ACC_ADD_D: if (!x0_zero && !y0_zero) acc_in = acc_ff + sat_q_ff;
         ALU_TEST_STOP: if (qualify && below) stop_in = 1'b1;
         ALU_TEST_WARN: if (qualify && below) warn_in = 1'b1;
         default: ;
      endcase
      // Flags start over once a frame's alert is handed to the result register.
      if (uc.emit && out_free) begin
         stop_in = 1'b0;
         warn_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      alert_in     = alert_ff;
      if (rsp_valid_ff && rsp_ch.ready)
         rsp_valid_in = 1'b0;
      if (uc.emit && out_free) begin
         rsp_valid_in = 1'b1;
         if (!warn_ff)
            alert_in = ALERT_CLEAR;
         else if (stop_ff)
            alert_in = ALERT_STOP;
         else
            alert_in = ALERT_WARN;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.alert_level = alert_ff;

   // Next step: jump, hold or fall through.
   always_comb begin
      case (uc.cond)
         COND_FRAME_DONE: cond_true = frame_done;
         COND_BUILD_MORE: cond_true = !build_last;
         COND_GRID_MORE:  cond_true = grid_more;
         COND_OUT_FREE:   cond_true = out_free;
         default:         cond_true = 1'b0;
      endcase
      if (cond_true)
         step_in = uc.target;
      else if (uc.hold)
         step_in = step_ff;
      else
         step_in = step_ff + STEP_W'(1);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= RST_FRAME_WIDTH;
         frame_height_ff  <= RST_FRAME_HEIGHT;
         patch_size_ff    <= RST_PATCH_SIZE;
         patch_stride_ff  <= RST_PATCH_STRIDE;
         min_points_ff    <= RST_MIN_POINTS;
         stop_thr_ff      <= RST_STOP_THRESHOLD;
         warn_thr_ff      <= RST_WARN_THRESHOLD;
         step_ff          <= STEP_LOAD;
         pixel_counter_ff <= '0;
         stop_ff          <= 1'b0;
         warn_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         patch_size_ff    <= patch_size_in;
         patch_stride_ff  <= patch_stride_in;
         min_points_ff    <= min_points_in;
         stop_thr_ff      <= stop_thr_in;
         warn_thr_ff      <= warn_thr_in;
         step_ff          <= step_in;
         pixel_counter_ff <= pixel_counter_in;
         stop_ff          <= stop_in;
         warn_ff          <= warn_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      row_ff   <= row_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      count_ff <= count_in;
      base1_ff <= base1_in;
      base0_ff <= base0_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      alert_ff <= alert_in;
   end

endmodule

@@ src/dppa_checker.sv @@
// Port-level checks for the depth patch proximity alarm, attached by bind.
// Depends on dppa_pkg and on the ports of depth_patch_proximity_alarm_top.
module dppa_checker import dppa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [ALERT_W-1:0] alert_level
);

   // Out of reset the block takes pixels and holds no result.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not loading and empty after reset");

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(alert_level))
      else $error("stalled result changed or dropped");

   // A new result is only issued after the input side has closed a frame.
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result issued while pixels were being taken");

   // Closing a frame always starts a walk that keeps the input closed.
   a_walk_length: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |=> !req_ready)
      else $error("input reopened right after a frame closed");

endmodule

bind depth_patch_proximity_alarm_top dppa_checker u_dppa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .alert_level (rsp_ch.alert_level)
);
